// ----- design/gbkccf_pkg.sv -----
// shared types and constants for the gbk character class filter
`default_nettype none
package gbkccf_pkg;

  typedef enum logic [2:0] {
    CLS_DIGIT   = 3'd0,
    CLS_SPACE   = 3'd1,
    CLS_LETTER  = 3'd2,
    CLS_HANZI   = 3'd3,
    CLS_UNKNOWN = 3'd4
  } char_class_t;

  typedef enum logic [2:0] {
    CFG_HANZI_MODE      = 3'd0,
    CFG_CLASS_DROP_MASK = 3'd1,
    CFG_SPACE_MODE      = 3'd2,
    CFG_FILTER_MODE     = 3'd3,
    CFG_WIDTH_MODE      = 3'd4,
    CFG_REPLACE_ENABLE  = 3'd5,
    CFG_REPLACE_SOURCE  = 3'd6,
    CFG_REPLACE_TARGET  = 3'd7
  } cfg_idx_t;

  localparam logic [1:0] HZ_KEEP = 2'd0;
  localparam logic [1:0] HZ_DROP = 2'd1;
  localparam logic [1:0] HZ_ONLY = 2'd2;
  localparam logic [1:0] HZ_ALT_DROP = 2'd3;

  localparam logic [1:0] SM_KEEP = 2'd0;
  localparam logic [1:0] SM_DROP_SPACE = 2'd1;
  localparam logic [1:0] SM_DROP_TAB = 2'd2;
  localparam logic [1:0] SM_DROP_ALL = 2'd3;

  localparam logic [1:0] FM_EDIT = 2'd0;
  localparam logic [1:0] FM_LINE = 2'd1;
  localparam logic [1:0] FM_DELETE = 2'd2;

  localparam logic [1:0] WM_NONE = 2'd0;
  localparam logic [1:0] WM_TO_HALF = 2'd1;
  localparam logic [1:0] WM_TO_FULL = 2'd2;

  localparam logic [1:0] VD_COPY = 2'd0;
  localparam logic [1:0] VD_EDIT = 2'd1;
  localparam logic [1:0] VD_DROP_LINE = 2'd2;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] FULL_LEAD = 8'hA3;
  localparam logic [7:0] HIGH_OFFSET = 8'h80;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic [7:0] lead_byte;
    logic [7:0] trail_byte;
    logic       trail_present;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_first;
    logic [7:0]  out_second;
    logic [1:0]  emit_count;
    logic [1:0]  consumed;
    logic [1:0]  verdict;
    char_class_t char_class;
  } out_beat_t;

endpackage
`default_nettype wire

// ----- design/gbk_char_class_filter_unit.sv -----
// top level of the gbk character class filter: classify and rewrite one character per beat
//
// input channel in_valid/in_stall/in_data carries one gbk character per beat:
// lead byte, trail byte and a flag telling whether the trail byte exists.
// output channel out_valid/out_stall/out_data returns exactly one result per
// character: up to two emitted bytes, their count, the bytes consumed, a
// verdict and the character class.
// from input beat to output beat a character passes one input register,
// then the classify and edit logic, then the result register.
// throughput is one character per cycle while out_stall stays low; both
// registers advance whenever the downstream side is free, so a new beat is
// taken while a result waits. when out_stall is high the result holds and
// in_stall rises only once the input register is also full.
// cfg_we/cfg_index/cfg_data write the eight mode registers; writes are taken
// at once and are meant to happen only while the block is empty.
// synchronous reset (rst_n low) empties both registers and clears all modes.
`default_nettype none
module gbk_char_class_filter_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  gbkccf_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output gbkccf_pkg::out_beat_t out_data,
  input  wire                   cfg_we,
  input  wire  [2:0]            cfg_index,
  input  wire  [7:0]            cfg_data
);

  logic [1:0] hanzi_mode_r;
  logic [1:0] class_drop_mask_r;
  logic [1:0] space_mode_r;
  logic [1:0] filter_mode_r;
  logic [1:0] width_mode_r;
  logic       replace_enable_r;
  logic [7:0] replace_source_r;
  logic [7:0] replace_target_r;

  logic                  s1_valid_r;
  gbkccf_pkg::in_beat_t  s1_data_r;
  logic                  out_valid_r;
  gbkccf_pkg::out_beat_t out_data_r;
  gbkccf_pkg::out_beat_t out_data_nxt;

  logic s2_en;
  logic s1_en;

  assign s2_en     = !out_valid_r || !out_stall;
  assign s1_en     = !s1_valid_r || s2_en;
  assign in_stall  = !s1_en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hanzi_mode_r      <= '0;
      class_drop_mask_r <= '0;
      space_mode_r      <= '0;
      filter_mode_r     <= '0;
      width_mode_r      <= '0;
      replace_enable_r  <= 1'b0;
      replace_source_r  <= '0;
      replace_target_r  <= '0;
    end else if (cfg_we) begin
      case (gbkccf_pkg::cfg_idx_t'(cfg_index))
        gbkccf_pkg::CFG_HANZI_MODE:      hanzi_mode_r      <= cfg_data[1:0];
        gbkccf_pkg::CFG_CLASS_DROP_MASK: class_drop_mask_r <= cfg_data[1:0];
        gbkccf_pkg::CFG_SPACE_MODE:      space_mode_r      <= cfg_data[1:0];
        gbkccf_pkg::CFG_FILTER_MODE:     filter_mode_r     <= cfg_data[1:0];
        gbkccf_pkg::CFG_WIDTH_MODE:      width_mode_r      <= cfg_data[1:0];
        gbkccf_pkg::CFG_REPLACE_ENABLE:  replace_enable_r  <= cfg_data[0];
        gbkccf_pkg::CFG_REPLACE_SOURCE:  replace_source_r  <= cfg_data;
        gbkccf_pkg::CFG_REPLACE_TARGET:  replace_target_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) s1_data_r <= in_data;
    if (s2_en && s1_valid_r) out_data_r <= out_data_nxt;
  end

  // classify and edit
  logic [7:0]              a;
  logic [7:0]              b;
  logic                    two_byte;
  logic [1:0]              step;
  gbkccf_pkg::char_class_t cls;
  logic                    drop_hz;
  logic                    drop_dg;
  logic                    drop_lt;
  logic                    is_tab;
  logic                    is_space;
  logic                    rep_hit;
  logic [7:0]              lower_a;
  logic                    conv_done;
  logic [7:0]              conv_first;
  logic [7:0]              conv_second;
  logic [1:0]              conv_count;
  logic                    kill;
  logic                    del;
  logic                    done;
  logic                    copy;
  logic [7:0]              o_first;
  logic [7:0]              o_second;
  logic [1:0]              o_count;
  logic [1:0]              o_verdict;

  assign a        = s1_data_r.lead_byte;
  assign b        = s1_data_r.trail_present ? s1_data_r.trail_byte : 8'h00;
  assign two_byte = (b != 8'h00) && (a > 8'h80) && (a != 8'hFF);
  assign step     = two_byte ? 2'd2 : 2'd1;
  assign drop_hz  = (hanzi_mode_r == gbkccf_pkg::HZ_DROP) ||
                    (hanzi_mode_r == gbkccf_pkg::HZ_ALT_DROP);
  assign drop_dg  = class_drop_mask_r[0];
  assign drop_lt  = class_drop_mask_r[1];
  assign is_tab   = (a == gbkccf_pkg::CH_TAB);
  assign is_space = (a == gbkccf_pkg::CH_SPACE);
  assign rep_hit  = replace_enable_r && (replace_source_r == a);
  assign lower_a  = (a inside {[8'h41:8'h5A]}) ? a + gbkccf_pkg::CASE_OFFSET : a;

  always_comb begin
    if (a inside {[8'h30:8'h39]}) begin
      cls = gbkccf_pkg::CLS_DIGIT;
    end else if (a == gbkccf_pkg::FULL_LEAD && (b inside {[8'hB0:8'hB9]})) begin
      cls = gbkccf_pkg::CLS_DIGIT;
    end else if (a inside {gbkccf_pkg::CH_TAB, gbkccf_pkg::CH_SPACE, 8'h80}) begin
      cls = gbkccf_pkg::CLS_SPACE;
    end else if ((a inside {[8'hA1:8'hA7]}) && b == 8'hA0) begin
      cls = gbkccf_pkg::CLS_SPACE;
    end else if (a inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
      cls = gbkccf_pkg::CLS_LETTER;
    end else if (a == gbkccf_pkg::FULL_LEAD && (b inside {[8'hC1:8'hDA], [8'hE1:8'hFA]})) begin
      cls = gbkccf_pkg::CLS_LETTER;
    end else if ((a inside {[8'h80:8'hA0], [8'hB0:8'hF7]}) &&
                 (b inside {[8'h40:8'hFE]}) && b != 8'h7F) begin
      cls = gbkccf_pkg::CLS_HANZI;
    end else if ((a inside {[8'hAA:8'hAF], [8'hF8:8'hFE]}) &&
                 (b inside {[8'h40:8'hA0]}) && b != 8'h7F) begin
      cls = gbkccf_pkg::CLS_HANZI;
    end else begin
      cls = gbkccf_pkg::CLS_UNKNOWN;
    end
  end

  // width conversion, then replacement
  always_comb begin
    conv_done   = 1'b1;
    conv_first  = 8'h00;
    conv_second = 8'h00;
    conv_count  = 2'd1;
    if (width_mode_r == gbkccf_pkg::WM_TO_HALF && two_byte) begin
      conv_first = b - gbkccf_pkg::HIGH_OFFSET;
    end else if (width_mode_r == gbkccf_pkg::WM_TO_FULL && !two_byte) begin
      conv_first  = gbkccf_pkg::FULL_LEAD;
      conv_second = lower_a + gbkccf_pkg::HIGH_OFFSET;
      conv_count  = 2'd2;
    end else if (rep_hit) begin
      conv_first = replace_target_r;
    end else begin
      conv_done  = 1'b0;
      conv_count = 2'd0;
    end
  end

  always_comb begin
    o_first   = 8'h00;
    o_second  = 8'h00;
    o_count   = 2'd0;
    o_verdict = gbkccf_pkg::VD_COPY;
    copy      = 1'b0;
    kill      = 1'b0;
    del       = 1'b0;
    done      = 1'b0;
    if (hanzi_mode_r == gbkccf_pkg::HZ_ONLY) begin
      if (cls == gbkccf_pkg::CLS_HANZI) begin
        o_first   = a;
        o_second  = b;
        o_count   = 2'd2;
        o_verdict = gbkccf_pkg::VD_EDIT;
      end else if (a == gbkccf_pkg::CH_NEWLINE) begin
        o_first = a;
        o_count = 2'd1;
      end else begin
        o_verdict = (filter_mode_r == gbkccf_pkg::FM_LINE) ?
                    gbkccf_pkg::VD_DROP_LINE : gbkccf_pkg::VD_EDIT;
      end
    end else if (filter_mode_r == gbkccf_pkg::FM_LINE) begin
      case (cls)
        gbkccf_pkg::CLS_DIGIT:  kill = drop_dg;
        gbkccf_pkg::CLS_HANZI:  kill = drop_hz;
        gbkccf_pkg::CLS_LETTER: kill = drop_lt;
        gbkccf_pkg::CLS_SPACE:
          kill = (space_mode_r == gbkccf_pkg::SM_DROP_ALL) ||
                 (space_mode_r == gbkccf_pkg::SM_DROP_TAB && is_tab) ||
                 (space_mode_r == gbkccf_pkg::SM_DROP_SPACE && is_space);
        default: kill = 1'b0;
      endcase
      if (kill) o_verdict = gbkccf_pkg::VD_DROP_LINE;
      else copy = 1'b1;
    end else if (filter_mode_r == gbkccf_pkg::FM_DELETE) begin
      del = (cls == gbkccf_pkg::CLS_HANZI && drop_hz) ||
            (cls == gbkccf_pkg::CLS_DIGIT && drop_dg) ||
            (cls == gbkccf_pkg::CLS_SPACE && space_mode_r != gbkccf_pkg::SM_KEEP) ||
            (cls == gbkccf_pkg::CLS_LETTER && drop_lt) ||
            (cls == gbkccf_pkg::CLS_UNKNOWN && a != gbkccf_pkg::CH_NEWLINE);
      if (del) o_verdict = gbkccf_pkg::VD_EDIT;
      else copy = 1'b1;
    end else begin
      case (cls)
        gbkccf_pkg::CLS_DIGIT: begin
          del  = drop_dg;
          done = !drop_dg && conv_done;
        end
        gbkccf_pkg::CLS_HANZI: del = drop_hz;
        gbkccf_pkg::CLS_SPACE: begin
          del  = (space_mode_r == gbkccf_pkg::SM_DROP_ALL) ||
                 (space_mode_r == gbkccf_pkg::SM_DROP_TAB && !two_byte && is_tab) ||
                 (space_mode_r == gbkccf_pkg::SM_DROP_SPACE && !two_byte && is_space);
          done = !del && conv_done;
        end
        gbkccf_pkg::CLS_LETTER: begin
          del  = drop_lt;
          done = !drop_lt && conv_done;
        end
        default: begin
          del  = 1'b0;
          done = !two_byte && rep_hit;
        end
      endcase
      if (done) begin
        if (cls == gbkccf_pkg::CLS_UNKNOWN) begin
          o_first = replace_target_r;
          o_count = 2'd1;
        end else begin
          o_first  = conv_first;
          o_second = conv_second;
          o_count  = conv_count;
        end
      end
      if (del || done) o_verdict = gbkccf_pkg::VD_EDIT;
      else copy = 1'b1;
    end
    if (copy) begin
      o_first   = a;
      o_second  = two_byte ? b : 8'h00;
      o_count   = step;
      o_verdict = gbkccf_pkg::VD_COPY;
    end
  end

  always_comb begin
    out_data_nxt.out_first  = o_first;
    out_data_nxt.out_second = o_second;
    out_data_nxt.emit_count = o_count;
    out_data_nxt.consumed   = step;
    out_data_nxt.verdict    = o_verdict;
    out_data_nxt.char_class = cls;
  end

endmodule
`default_nettype wire
